[design/ascii_frame_checker_macros.svh]
// Assertion macros for the ascii frame checker
`ifndef ASCII_FRAME_CHECKER_MACROS_SVH
`define ASCII_FRAME_CHECKER_MACROS_SVH

// same-cycle implication, disabled in reset
`define AFC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define AFC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/afc_pkg.sv]
// Types, constants and helper functions of the ascii frame checker
package afc_pkg;

    localparam int BYTE_W         = 8;
    localparam int SRC_W          = 24;
    localparam int CMD_W          = 32;
    localparam int VALUE_W        = 31;
    localparam int LEN_W          = 10;
    localparam int CRC_W          = 8;
    localparam int DIGIT_W        = 4;
    localparam int CRC_NUM_W      = 10;

    localparam int SRC_END        = 3;
    localparam int DST_END        = 6;
    localparam int LEN_END        = 9;
    localparam int HEADER_BYTES   = 13;
    localparam int OVERHEAD_BYTES = 16;

    localparam logic [CRC_W-1:0]   CRC_POLY      = 8'h07;
    localparam logic [BYTE_W-1:0]  CHAR_0        = 8'h30;
    localparam logic [BYTE_W-1:0]  CHAR_9        = 8'h39;
    localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 10'd252;
    localparam logic [VALUE_W-1:0] VALUE_MAX     = {VALUE_W{1'b1}};

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_LENGTH   = 3'd1,
        ST_BAD_FORMAT   = 3'd2,
        ST_CRC_MISMATCH = 3'd3,
        ST_NO_VALUE     = 3'd4
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_end;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [SRC_W-1:0]   source_address;
        logic [CMD_W-1:0]   command_code;
        logic [VALUE_W-1:0] data_value;
    } t_result;

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= CHAR_0) && (b <= CHAR_9);
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_val(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = b - CHAR_0;
        return d[DIGIT_W-1:0];
    endfunction

    function automatic logic [CRC_W-1:0] crc8_update(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[design/afc_in_if.sv]
// Input byte channel of the ascii frame checker
interface afc_in_if;
    import afc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

[design/afc_out_if.sv]
// Result channel of the ascii frame checker
interface afc_out_if;
    import afc_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic [SRC_W-1:0]   source_address;
    logic [CMD_W-1:0]   command_code;
    logic [VALUE_W-1:0] data_value;

    modport source (output valid, output status, output source_address,
                    output command_code, output data_value, input ready);
    modport sink   (input valid, input status, input source_address,
                    input command_code, input data_value, output ready);
endinterface

[design/afc_cfg_if.sv]
// Configuration write channel of the ascii frame checker
interface afc_cfg_if;
    import afc_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_data_length;

    modport source (output valid, output max_data_length, input ready);
    modport sink   (input valid, input max_data_length, output ready);
endinterface

[design/ascii_frame_checker.sv]
// Top level of the ascii frame checker
//
// i_frame carries the frame body one byte per transaction, frame_end set on
// the final byte. For each frame, one transaction on o_result gives the status
// (ok, bad length, bad format, crc mismatch, no value), source, command and
// the saturated decimal data value (zero unless ok). i_cfg writes
// max_data_length; write it only while no frame is in flight.
// Throughput: one byte per cycle; a final byte waits while the result is
// held. Every byte passes an input register and one pass of field, length,
// value and CRC-8 update logic; a final byte's result is then registered.
// Reset clears the frame state and both stages, and sets max_data_length to
// 252. While o_result is held valid and not ready, non-final bytes still flow;
// a final byte waits in the input register and i_frame.ready drops until the
// result register is free. MAX_FRAME_BYTES bounds the byte count; longer
// frames report bad length.
module ascii_frame_checker #(
    parameter int MAX_FRAME_BYTES = 511
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    afc_in_if.sink    i_frame,
    afc_cfg_if.sink   i_cfg,
    afc_out_if.source o_result
);
    import afc_pkg::*;

    logic [LEN_W-1:0] r_max_data_length;
    logic             step;
    logic             out_free;
    logic             result_valid;
    t_in_item         item;
    t_result          result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_data_length <= MAX_LEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_data_length <= i_cfg.max_data_length;
        end
    end

    afc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (i_frame),
        .i_out_free (out_free),
        .o_step     (step),
        .o_item     (item)
    );

    afc_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (item),
        .i_max_len      (r_max_data_length),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    afc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (result_valid),
        .i_result (result),
        .o_free   (out_free),
        .o_result (o_result)
    );
endmodule

[design/afc_in_stage.sv]
// Input register stage with advance control
module afc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    afc_in_if.sink            i_frame,
    input  logic              i_out_free,
    output logic              o_step,
    output afc_pkg::t_in_item o_item
);
    import afc_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    assign o_step        = r_valid && (!r_item.frame_end || i_out_free);
    assign i_frame.ready = !r_valid || o_step;
    assign accept        = i_frame.valid && i_frame.ready;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_step) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_item.frame_byte <= i_frame.frame_byte;
            r_item.frame_end  <= i_frame.frame_end;
        end
    end
endmodule

[design/afc_parser.sv]
// Frame field capture, CRC accumulation and final verdict
module afc_parser #(
    parameter int MAX_FRAME_BYTES = 511
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  afc_pkg::t_in_item        i_item,
    input  logic [afc_pkg::LEN_W-1:0] i_max_len,
    output logic                     o_result_valid,
    output afc_pkg::t_result         o_result
);
    import afc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
    localparam int LW = ((CW > LEN_W + 1) ? CW : LEN_W + 1) + 1;
    localparam int PW = VALUE_W + DIGIT_W;

    logic [CW-1:0]      r_count,   n_count;
    logic [CRC_W-1:0]   r_crc,     n_crc;
    logic [BYTE_W-1:0]  r_tail0,   r_tail1,  r_tail2;
    logic [SRC_W-1:0]   r_source,  n_source;
    logic [LEN_W-1:0]   r_len,     n_len;
    logic               r_len_bad, n_len_bad;
    logic [CMD_W-1:0]   r_cmd,     n_cmd;
    logic [VALUE_W-1:0] r_value,   n_value;
    logic               r_val_bad, n_val_bad;

    logic [BYTE_W-1:0]    b;
    logic [LW-1:0]        pos_ext;
    logic [LW-1:0]        data_lim;
    logic [PW-1:0]        prod;
    logic [LEN_W+3:0]     len_prod;
    logic [CRC_NUM_W-1:0] crc_num;
    t_status              status;

    assign b        = i_item.frame_byte;
    assign pos_ext  = LW'(r_count);
    assign data_lim = LW'(HEADER_BYTES) + LW'(r_len);
    assign prod     = (PW'(r_value) * PW'(10)) + PW'(digit_val(b));
    assign len_prod = ((LEN_W+4)'(r_len) * (LEN_W+4)'(10)) + (LEN_W+4)'(digit_val(b));
    assign crc_num  = (CRC_NUM_W'(digit_val(r_tail1)) * CRC_NUM_W'(100))
                    + (CRC_NUM_W'(digit_val(r_tail2)) * CRC_NUM_W'(10))
                    + CRC_NUM_W'(digit_val(b));

    always_comb begin
        n_crc     = r_crc;
        n_source  = r_source;
        n_len     = r_len;
        n_len_bad = r_len_bad;
        n_cmd     = r_cmd;
        n_value   = r_value;
        n_val_bad = r_val_bad;

        if (r_count >= CW'(SRC_END)) begin
            n_crc = crc8_update(r_crc, r_tail0);
        end

        if (r_count < CW'(SRC_END)) begin
            n_source = {r_source[SRC_W-BYTE_W-1:0], b};
        end else if (r_count >= CW'(DST_END) && r_count < CW'(LEN_END)) begin
            if (is_digit(b)) begin
                n_len = len_prod[LEN_W-1:0];
            end else begin
                n_len_bad = 1'b1;
            end
        end else if (r_count >= CW'(LEN_END) && r_count < CW'(HEADER_BYTES)) begin
            n_cmd = {r_cmd[CMD_W-BYTE_W-1:0], b};
        end else if (pos_ext >= LW'(HEADER_BYTES) && pos_ext < data_lim) begin
            if (is_digit(b)) begin
                n_value = (prod > PW'(VALUE_MAX)) ? VALUE_MAX : prod[VALUE_W-1:0];
            end else begin
                n_val_bad = 1'b1;
            end
        end

        n_count = (r_count <= CW'(MAX_FRAME_BYTES)) ? r_count + CW'(1) : r_count;
    end

    always_comb begin
        if (n_count < CW'(OVERHEAD_BYTES) || n_count > CW'(MAX_FRAME_BYTES)) begin
            status = ST_BAD_LENGTH;
        end else if (n_len_bad) begin
            status = ST_BAD_FORMAT;
        end else if (n_len > i_max_len ||
                     LW'(n_count) != LW'(n_len) + LW'(OVERHEAD_BYTES)) begin
            status = ST_BAD_LENGTH;
        end else if (!is_digit(r_tail1) || !is_digit(r_tail2) || !is_digit(b)) begin
            status = ST_BAD_FORMAT;
        end else if (crc_num != CRC_NUM_W'(n_crc)) begin
            status = ST_CRC_MISMATCH;
        end else if (n_val_bad) begin
            status = ST_NO_VALUE;
        end else begin
            status = ST_OK;
        end
    end

    assign o_result_valid          = i_step && i_item.frame_end;
    assign o_result.status         = status;
    assign o_result.source_address = n_source;
    assign o_result.command_code   = n_cmd;
    assign o_result.data_value     = (status == ST_OK) ? n_value : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.frame_end)) begin
            r_count   <= '0;
            r_crc     <= '0;
            r_tail0   <= '0;
            r_tail1   <= '0;
            r_tail2   <= '0;
            r_source  <= '0;
            r_len     <= '0;
            r_len_bad <= 1'b0;
            r_cmd     <= '0;
            r_value   <= '0;
            r_val_bad <= 1'b0;
        end else if (i_step) begin
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_tail0   <= r_tail1;
            r_tail1   <= r_tail2;
            r_tail2   <= b;
            r_source  <= n_source;
            r_len     <= n_len;
            r_len_bad <= n_len_bad;
            r_cmd     <= n_cmd;
            r_value   <= n_value;
            r_val_bad <= n_val_bad;
        end
    end
endmodule

[design/afc_out_stage.sv]
// Result register driving the output channel
module afc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  afc_pkg::t_result i_result,
    output logic             o_free,
    afc_out_if.source        o_result
);
    import afc_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free                  = !r_valid || o_result.ready;
    assign o_result.valid          = r_valid;
    assign o_result.status         = r_data.status;
    assign o_result.source_address = r_data.source_address;
    assign o_result.command_code   = r_data.command_code;
    assign o_result.data_value     = r_data.data_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_data <= i_result;
        end
    end
endmodule

[design/afc_checker.sv]
// Port-level assertions for the ascii frame checker and their bind
`include "ascii_frame_checker_macros.svh"

module afc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_in_end,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  afc_pkg::t_status            i_status,
    input  logic [afc_pkg::SRC_W-1:0]   i_source,
    input  logic [afc_pkg::CMD_W-1:0]   i_command,
    input  logic [afc_pkg::VALUE_W-1:0] i_value
);
    import afc_pkg::*;

    `AFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_status) && $stable(i_source) && $stable(i_command) &&
        $stable(i_value), "result changed while stalled")

    `AFC_ASSERT_IMPL(a_value_zero, i_clk, i_rst_n, i_out_valid && i_status != ST_OK,
        i_value == '0, "data value set on a failed frame")

    `AFC_ASSERT_IMPL(a_result_from_end, i_clk, i_rst_n, $rose(i_out_valid),
        $past(i_in_valid && i_in_ready && i_in_end, 2), "result without a final byte")

    `AFC_ASSERT_IMPL(a_ready_low_stall, i_clk, i_rst_n, !i_in_ready,
        i_out_valid && !i_out_ready, "input stalled with a free result register")
endmodule

bind ascii_frame_checker afc_checker u_afc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_frame.valid),
    .i_in_ready  (i_frame.ready),
    .i_in_end    (i_frame.frame_end),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_status    (o_result.status),
    .i_source    (o_result.source_address),
    .i_command   (o_result.command_code),
    .i_value     (o_result.data_value)
);
